// ----- sv/joc_pkg.sv -----
// Shared types and constants for the joystick octant commander.
// Holds command codes, register indexes, field widths and reset values.
// No dependencies.
package joc_pkg;

    // Command codes carried in the result word
    typedef enum logic [3:0] {
        CMD_BRAKE = 4'd0,
        CMD_FR    = 4'd1,
        CMD_FX    = 4'd2,
        CMD_FF    = 4'd3,
        CMD_XF    = 4'd4,
        CMD_RF    = 4'd5,
        CMD_XR    = 4'd6,
        CMD_RR    = 4'd7,
        CMD_RX    = 4'd8
    } cmd_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_DEAD_ZONE = 2'd0;
    localparam cfg_idx_t REG_RADIUS_SQ = 2'd1;
    localparam cfg_idx_t REG_HOLD_MS   = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic [6:0]  DEAD_ZONE_RST = 7'd15;
    localparam logic [15:0] RADIUS_SQ_RST = 16'd6400;
    localparam logic [15:0] HOLD_MS_RST   = 16'd2000;

    // Axis centre
    localparam logic [8:0] AXIS_CENTRE = 9'd128;

    // Word widths, rounded up to whole bytes
    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 32;

endpackage

// ----- sv/joystick_octant_commander.sv -----
// Joystick octant commander: dead zone, button edges, sector sort and hold timer.
// Single module; depends on joc_pkg.
//
// A sample word goes through the stage A register, then the result register.
// One word per cycle unless m_tready stalls; stage A centres the axes and
// forms the squares, stage B does the sector compares, 32-bit hold timer, state.
// Reset (aresetn low, synchronous): both stages empty, registers at defaults,
// button history and held command cleared.
module joystick_octant_commander (
    input  logic                              aclk,
    input  logic                              aresetn,
    // sample channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] read_ok, [8:1] stick_x, [16:9] stick_y, [17] button_c, [18] button_z,
    // [50:19] now_ms, [55:51] zero
    input  logic [joc_pkg::S_DATA_W-1:0]      s_tdata,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] report_valid, [8:1] move_x, [17:9] move_y, [18] left_press,
    // [19] left_release, [20] right_press, [21] right_release, [22] cmd_valid,
    // [26:23] cmd_code, [31:27] zero
    output logic [joc_pkg::M_DATA_W-1:0]      m_tdata,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [joc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [joc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import joc_pkg::*;

    // Configuration registers
    logic [6:0]  dead_zone_reg;
    logic [15:0] radius_sq_reg;
    logic [15:0] hold_ms_reg;

    // Stage A register (centred sample and squares)
    logic               a_valid_reg;
    logic               a_ok_reg;
    logic signed [8:0]  a_x_reg;
    logic signed [8:0]  a_y_reg;
    logic               a_c_reg;
    logic               a_z_reg;
    logic [31:0]        a_now_reg;
    logic [14:0]        a_x2_reg;
    logic [14:0]        a_y2_reg;
    logic [16:0]        a_s2_reg;

    // Item state
    logic        prev_c_reg;
    logic        prev_z_reg;
    logic [31:0] last_dir_reg;
    cmd_t        held_cmd_reg;
    logic        held_known_reg;

    // Result register
    logic                  m_valid_reg;
    logic [M_DATA_W-1:0]   m_data_reg;

    // Handshake
    logic out_free;
    logic adv;
    logic s_acc;

    assign out_free  = !m_valid_reg || m_tready;
    assign adv       = a_valid_reg && out_free;
    assign s_tready  = !a_valid_reg || out_free;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Centre an axis and zero it inside the dead zone
    function automatic logic signed [8:0] centre_axis(input logic [7:0] raw,
                                                      input logic [6:0] dz);
        logic signed [8:0] v;
        logic [8:0]        neg;
        logic [7:0]        mag;
        v   = $signed({1'b0, raw} - AXIS_CENTRE);
        neg = 9'(-v);
        mag = v[8] ? neg[7:0] : v[7:0];
        return (mag < {1'b0, dz}) ? 9'sd0 : v;
    endfunction

    // Stage A: centre and square
    logic signed [8:0] sx_c, sy_c;
    logic [8:0]        sx_n, sy_n;
    logic [7:0]        ax, ay;
    logic [8:0]        axy;
    logic [15:0]       x2_full, y2_full;
    logic [17:0]       s2_full;

    always_comb begin
        sx_c    = centre_axis(s_tdata[8:1], dead_zone_reg);
        sy_c    = centre_axis(s_tdata[16:9], dead_zone_reg);
        sx_n    = 9'(-sx_c);
        sy_n    = 9'(-sy_c);
        ax      = sx_c[8] ? sx_n[7:0] : sx_c[7:0];
        ay      = sy_c[8] ? sy_n[7:0] : sy_c[7:0];
        axy     = {1'b0, ax} + {1'b0, ay};
        x2_full = 16'(ax) * 16'(ax);
        y2_full = 16'(ay) * 16'(ay);
        s2_full = 18'(axy) * 18'(axy);
    end

    // Stage B: sector sort, hold window and button edges
    logic [15:0] r_sq;
    logic        dir_hit;
    logic        new_dir;
    logic        near_x, near_y;
    cmd_t        sector;
    cmd_t        code;
    logic        known_eff;
    cmd_t        held_eff;
    logic [31:0] last_eff;
    logic [31:0] elapsed;
    logic        cmd_on;
    logic        lp, lr, rp, rr;
    logic signed [8:0] my;

    always_comb begin
        r_sq    = {1'b0, a_x2_reg} + {1'b0, a_y2_reg};
        dir_hit = r_sq > radius_sq_reg;
        new_dir = a_ok_reg && dir_hit;
        near_x  = a_s2_reg < {1'b0, a_x2_reg, 1'b0};
        near_y  = a_s2_reg < {1'b0, a_y2_reg, 1'b0};
        if (near_x) begin
            sector = (a_x_reg > 9'sd0) ? CMD_FR : CMD_RF;
        end else if (near_y) begin
            sector = (a_y_reg > 9'sd0) ? CMD_FF : CMD_RR;
        end else if (a_x_reg > 9'sd0) begin
            sector = (a_y_reg > 9'sd0) ? CMD_FX : CMD_RX;
        end else begin
            sector = (a_y_reg > 9'sd0) ? CMD_XF : CMD_XR;
        end
        code      = dir_hit ? sector : CMD_BRAKE;
        known_eff = held_known_reg || a_ok_reg;
        held_eff  = a_ok_reg ? code : held_cmd_reg;
        last_eff  = new_dir ? a_now_reg : last_dir_reg;
        // a fresh direction restarts the window, so it is always inside it
        elapsed   = a_now_reg - last_dir_reg;
        cmd_on    = known_eff && (new_dir || (elapsed <= {16'd0, hold_ms_reg}));
        lp        = a_ok_reg && a_c_reg && !prev_c_reg;
        lr        = a_ok_reg && !a_c_reg && prev_c_reg;
        rp        = a_ok_reg && a_z_reg && !prev_z_reg;
        rr        = a_ok_reg && !a_z_reg && prev_z_reg;
        my        = a_ok_reg ? 9'(-a_y_reg) : 9'sd0;
    end

    logic [M_DATA_W-1:0] m_data_next;
    always_comb begin
        m_data_next        = '0;
        m_data_next[0]     = a_ok_reg;
        m_data_next[8:1]   = a_ok_reg ? a_x_reg[7:0] : 8'd0;
        m_data_next[17:9]  = my;
        m_data_next[18]    = lp;
        m_data_next[19]    = lr;
        m_data_next[20]    = rp;
        m_data_next[21]    = rr;
        m_data_next[22]    = cmd_on;
        m_data_next[26:23] = cmd_on ? held_eff : CMD_BRAKE;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg <= DEAD_ZONE_RST;
            radius_sq_reg <= RADIUS_SQ_RST;
            hold_ms_reg   <= HOLD_MS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEAD_ZONE: dead_zone_reg <= cfg_data[6:0];
                REG_RADIUS_SQ: radius_sq_reg <= cfg_data;
                REG_HOLD_MS:   hold_ms_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage A register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
        if (s_acc) begin
            a_ok_reg  <= s_tdata[0];
            a_x_reg   <= sx_c;
            a_y_reg   <= sy_c;
            a_c_reg   <= s_tdata[17];
            a_z_reg   <= s_tdata[18];
            a_now_reg <= s_tdata[50:19];
            a_x2_reg  <= x2_full[14:0];
            a_y2_reg  <= y2_full[14:0];
            a_s2_reg  <= s2_full[16:0];
        end
    end

    // Item state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_c_reg     <= 1'b0;
            prev_z_reg     <= 1'b0;
            last_dir_reg   <= '0;
            held_cmd_reg   <= CMD_BRAKE;
            held_known_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= a_valid_reg;
            end
            if (adv) begin
                m_data_reg     <= m_data_next;
                held_known_reg <= known_eff;
                held_cmd_reg   <= held_eff;
                last_dir_reg   <= last_eff;
                if (a_ok_reg) begin
                    prev_c_reg <= a_c_reg;
                    prev_z_reg <= a_z_reg;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    // A known command never becomes unknown again
    a_known_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        held_known_reg |=> held_known_reg)
        else $error("held command lost its known flag");

    // With no command, the code field is brake
    a_code_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[22]) |-> (m_data_reg[26:23] == CMD_BRAKE))
        else $error("command code set without cmd_valid");

    // A failed read carries no motion and no edges
    a_bad_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[0]) |-> (m_data_reg[21:1] == '0))
        else $error("motion or edges reported on a failed read");

    // A press and a release of one button never come together
    a_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[18] && m_data_reg[19])
                     && !(m_data_reg[20] && m_data_reg[21]))
        else $error("press and release on one button in one word");

    // A stage A word blocked by the result register stays put
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !out_free) |=> a_valid_reg)
        else $error("stage A word dropped while result stalled");
`endif

endmodule
